>>> sv/hee_pkg.sv
// ---------------------------------------------------------------------------
// HTML entity escaper package
// Character codes, entity selection, entity text table and the beat structs
// shared by the escaper modules.
// ---------------------------------------------------------------------------
package hee_pkg;

   localparam int ENT_MAX_LEN = 6;
   localparam int IDX_W       = 3;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_QUOT  = 8'h22;
   localparam logic [7:0] CHAR_APOS  = 8'h27;
   localparam logic [7:0] CHAR_GRAVE = 8'h60;

   localparam logic [7:0] CTRL_LAST_LOW = 8'h08;
   localparam logic [7:0] CTRL_VT       = 8'h0B;
   localparam logic [7:0] CTRL_FF       = 8'h0C;
   localparam logic [7:0] CTRL_HI_FIRST = 8'h0E;
   localparam logic [7:0] CTRL_HI_LAST  = 8'h1F;

   localparam logic MODE_ATTR = 1'b0;
   localparam logic MODE_TEXT = 1'b1;

   // Entity text, left aligned, zero padded to six characters
   localparam logic [47:0] TEXT_LT    = {"&lt;", 16'h0000};
   localparam logic [47:0] TEXT_GT    = {"&gt;", 16'h0000};
   localparam logic [47:0] TEXT_AMP   = {"&amp;", 8'h00};
   localparam logic [47:0] TEXT_QUOT  = "&quot;";
   localparam logic [47:0] TEXT_APOS  = "&apos;";
   localparam logic [47:0] TEXT_GRAVE = "&#096;";

   typedef enum logic [2:0] {
      ENT_NONE,
      ENT_LT,
      ENT_GT,
      ENT_AMP,
      ENT_QUOT,
      ENT_APOS,
      ENT_GRAVE
   } ent_sel_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       data_valid;
      logic       last_of_run;
      logic       text_end;
   } beat_type;

   typedef struct packed {
      logic     emit;
      beat_type beat;
   } class_type;

   function automatic logic [IDX_W-1:0] ent_len(input ent_sel_type sel);
      logic [IDX_W-1:0] len;
      unique case (sel)
         ENT_LT, ENT_GT:              len = IDX_W'(4);
         ENT_AMP:                     len = IDX_W'(5);
         ENT_QUOT, ENT_APOS, ENT_GRAVE: len = IDX_W'(6);
         default:                     len = IDX_W'(1);
      endcase
      return len;
   endfunction

   function automatic logic [7:0] ent_char(input ent_sel_type sel,
                                           input logic [IDX_W-1:0] idx);
      logic [47:0] text;
      logic [47:0] shifted;
      unique case (sel)
         ENT_LT:    text = TEXT_LT;
         ENT_GT:    text = TEXT_GT;
         ENT_AMP:   text = TEXT_AMP;
         ENT_QUOT:  text = TEXT_QUOT;
         ENT_APOS:  text = TEXT_APOS;
         ENT_GRAVE: text = TEXT_GRAVE;
         default:   text = '0;
      endcase
      shifted = text << {idx, 3'b000};
      return shifted[47:40];
   endfunction

endpackage

>>> sv/hee_req_if.sv
// ---------------------------------------------------------------------------
// Escaper request channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ---------------------------------------------------------------------------
interface hee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_text;

   modport source (output valid, output byte_value, output end_of_text, input ready);
   modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

>>> sv/hee_rsp_if.sv
// ---------------------------------------------------------------------------
// Escaper response channel
// Valid/ready channel carrying one escaped output byte and its markers.
// ---------------------------------------------------------------------------
interface hee_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       data_valid;
   logic       last_of_run;
   logic       text_end;

   modport source (output valid, output byte_out, output data_valid,
                   output last_of_run, output text_end, input ready);
   modport sink   (input valid, input byte_out, input data_valid,
                   input last_of_run, input text_end, output ready);
endinterface

>>> sv/html_entity_escaper_unit.sv
// ---------------------------------------------------------------------------
// HTML entity escaper unit
// Takes one text byte per beat and returns the escaped byte stream.
//
//   channel | direction | payload
//   req_ch  | in        | byte_value[7:0], end_of_text
//   rsp_ch  | out       | byte_out[7:0], data_valid, last_of_run, text_end
//   csr     | in        | csr_write_en, csr_write_data (escape_mode)
//
// Plain bytes stream at one per cycle while rsp_ch.ready does not stall the output.
// An entity holds the input register until all of its four to six characters move out.
// A silently dropped control byte frees the input register without waiting on the output.
// A request reaches the response through the input register, then the output register.
// Reset clears both valid flags and escape_mode; rsp_ch.ready low stalls
// the output register and, through it, the input register.
// ---------------------------------------------------------------------------
module html_entity_escaper_unit (
   input  logic      clock,
   input  logic      reset,
   hee_req_if.sink   req_ch,
   hee_rsp_if.source rsp_ch,
   input  logic      csr_write_en,
   input  logic      csr_write_data
);
   import hee_pkg::*;

   logic             mode_ff;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [7:0]       s1_byte_ff;
   logic             s1_end_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [IDX_W-1:0] s1_idx_in;
   class_type        cls;
   logic             out_can_take;
   logic             step;
   logic             finish;
   logic             accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ATTR;
      end else if (csr_write_en) begin
         mode_ff <= csr_write_data;
      end
   end

   hee_classify u_classify (
      .byte_value  (s1_byte_ff),
      .end_of_text (s1_end_ff),
      .idx         (s1_idx_ff),
      .escape_mode (mode_ff),
      .cls         (cls)
   );

   hee_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_valid_ff && cls.emit),
      .load_beat  (cls.beat),
      .can_take   (out_can_take),
      .rsp_ch     (rsp_ch)
   );

   // Advance one position when a beat moves out, or at once for a byte that emits no beat
   assign step   = s1_valid_ff && (!cls.emit || out_can_take);
   assign finish = step && cls.beat.last_of_run;
   assign req_ch.ready = !s1_valid_ff || finish;
   assign accept = req_ch.valid && req_ch.ready;

   assign s1_valid_in = accept || (s1_valid_ff && !finish);

   always_comb begin
      if (accept) begin
         s1_idx_in = '0;
      end else if (step) begin
         s1_idx_in = s1_idx_ff + IDX_W'(1);
      end else begin
         s1_idx_in = s1_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_idx_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_idx_ff   <= s1_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_ch.byte_value;
         s1_end_ff  <= req_ch.end_of_text;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_idx_ff < IDX_W'(ENT_MAX_LEN))
      else $error("entity position beyond longest entity");

   a_hold_mid_entity: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !finish) |-> !req_ch.ready)
      else $error("request taken while an entity is still expanding");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.data_valid) |-> (rsp_ch.last_of_run && rsp_ch.text_end))
      else $error("empty response beat without end marker");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && cls.emit && cls.beat.text_end) |-> cls.beat.last_of_run)
      else $error("text end flagged before the last beat of its byte");

endmodule

>>> sv/hee_classify.sv
// ---------------------------------------------------------------------------
// Escaper byte classifier
// Picks the entity for a held byte and forms the beat at the given position.
// ---------------------------------------------------------------------------
module hee_classify (
   input  logic [7:0]              byte_value,
   input  logic                    end_of_text,
   input  logic [hee_pkg::IDX_W-1:0] idx,
   input  logic                    escape_mode,
   output hee_pkg::class_type      cls
);
   import hee_pkg::*;

   ent_sel_type      sel;
   logic             is_ctrl;
   logic             drop;
   logic             last;
   logic [IDX_W-1:0] len;

   always_comb begin
      unique case (byte_value)
         CHAR_LT:    sel = ENT_LT;
         CHAR_GT:    sel = ENT_GT;
         CHAR_AMP:   sel = ENT_AMP;
         CHAR_QUOT:  sel = (escape_mode == MODE_ATTR) ? ENT_QUOT  : ENT_NONE;
         CHAR_APOS:  sel = (escape_mode == MODE_ATTR) ? ENT_APOS  : ENT_NONE;
         CHAR_GRAVE: sel = (escape_mode == MODE_ATTR) ? ENT_GRAVE : ENT_NONE;
         default:    sel = ENT_NONE;
      endcase
   end

   assign is_ctrl = (byte_value <= CTRL_LAST_LOW) || (byte_value == CTRL_VT) ||
                    (byte_value == CTRL_FF) ||
                    (byte_value >= CTRL_HI_FIRST && byte_value <= CTRL_HI_LAST);
   assign drop    = (escape_mode == MODE_TEXT) && is_ctrl;
   assign len     = ent_len(sel);
   assign last    = (sel == ENT_NONE) || (idx == len - IDX_W'(1));

   always_comb begin
      cls.emit             = !drop || end_of_text;
      cls.beat.data_valid  = !drop;
      cls.beat.last_of_run = last;
      cls.beat.text_end    = last && end_of_text;
      if (drop) begin
         cls.beat.byte_out = 8'h00;
      end else if (sel == ENT_NONE) begin
         cls.beat.byte_out = byte_value;
      end else begin
         cls.beat.byte_out = ent_char(sel, idx);
      end
   end

endmodule

>>> sv/hee_out_stage.sv
// ---------------------------------------------------------------------------
// Escaper output register
// Holds one response beat until the sink takes it.
// ---------------------------------------------------------------------------
module hee_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  hee_pkg::beat_type load_beat,
   output logic              can_take,
   hee_rsp_if.source         rsp_ch
);
   import hee_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;

   assign can_take = !valid_ff || rsp_ch.ready;
   assign valid_in = (load_valid && can_take) || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && can_take) begin
         beat_ff <= load_beat;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.byte_out    = beat_ff.byte_out;
   assign rsp_ch.data_valid  = beat_ff.data_valid;
   assign rsp_ch.last_of_run = beat_ff.last_of_run;
   assign rsp_ch.text_end    = beat_ff.text_end;

endmodule
